// ===== hw/rtl/ads_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ads_pkg
// Shared types and constants of the advection-diffusion stencil.
// ----------------------------------------------------------------------------
package ads_pkg;

  localparam int VAL_W      = 32;
  localparam int WGT_W      = 18;
  localparam int GW_W       = 11;
  localparam int GH_W       = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;
  localparam int PROD_W     = VAL_W + WGT_W;
  localparam int ACC_W      = PROD_W + 3;
  localparam int FRAC_W     = 16;
  localparam int QUO_W      = ACC_W - FRAC_W;
  localparam int FIFO_DEPTH = 16;
  localparam int FIFO_AW    = 4;

  localparam logic signed [ACC_W-1:0] RND_BIAS = ACC_W'(32768);
  localparam logic signed [VAL_W-1:0] VAL_MAX  = 32'sh7fff_ffff;
  localparam logic signed [VAL_W-1:0] VAL_MIN  = 32'sh8000_0000;

  localparam logic signed [WGT_W-1:0] RST_WC = 18'sd58046;
  localparam logic signed [WGT_W-1:0] RST_WL = 18'sd11235;
  localparam logic signed [WGT_W-1:0] RST_WR = -18'sd7490;
  localparam logic signed [WGT_W-1:0] RST_WD = 18'sd11235;
  localparam logic signed [WGT_W-1:0] RST_WU = -18'sd7490;
  localparam logic [GW_W-1:0]         RST_GW = 11'd258;
  localparam logic [GH_W-1:0]         RST_GH = 13'd128;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WC     = 3'd0,
    REG_WL     = 3'd1,
    REG_WR     = 3'd2,
    REG_WD     = 3'd3,
    REG_WU     = 3'd4,
    REG_WIDTH  = 3'd5,
    REG_HEIGHT = 3'd6
  } cfg_reg_t;

  // per item control carried along the pipeline
  typedef struct packed {
    logic emit;    // a result for the row above
    logic pass;    // that result is the centre unchanged
    logic second;  // last row: the incoming cell follows
    logic done;    // final column of the grid
  } item_ctl_t;

endpackage
`default_nettype wire

// ===== hw/rtl/ads_line_buf.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ads_line_buf
// Raster counters and the two line memories; gathers stencil operands.
// ----------------------------------------------------------------------------
module ads_line_buf #(
  parameter int MAX_WIDTH = 1024,
  parameter int CW        = 10,
  parameter int RW        = 12
) (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             restart,
  input  wire                             accept,
  input  wire  [ads_pkg::VAL_W-1:0]       cell_data,
  input  wire  [CW-1:0]                   last_col,
  input  wire  [RW-1:0]                   last_row,
  output logic                            s1_valid,
  output ads_pkg::item_ctl_t              s1_ctl,
  output logic [RW-1:0]                   s1_row,
  output logic [CW-1:0]                   s1_col,
  output logic [ads_pkg::VAL_W-1:0]       s1_x,
  output logic [ads_pkg::VAL_W-1:0]       s1_ctr,
  output logic [ads_pkg::VAL_W-1:0]       s1_dn,
  output logic [ads_pkg::VAL_W-1:0]       s1_lft,
  output logic [ads_pkg::VAL_W-1:0]       rgt
);
  import ads_pkg::*;

  logic [VAL_W-1:0] rec_mem [MAX_WIDTH];
  logic [VAL_W-1:0] old_mem [MAX_WIDTH];
  logic [VAL_W-1:0] rec_rd;
  logic [VAL_W-1:0] old_rd;
  logic [VAL_W-1:0] prev_ctr;
  logic [CW-1:0]    col;
  logic [RW-1:0]    row;
  logic [CW-1:0]    rd_addr;
  logic             at_last_col;

  assign at_last_col = (col == last_col);
  // look one column ahead, wrapping to the start of the next row
  assign rd_addr = at_last_col ? '0 : col + CW'(1);
  assign rgt = rec_rd;

  always_ff @(posedge clk) begin
    if (accept) begin
      rec_mem[col] <= cell_data;
      rec_rd       <= rec_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      old_mem[col] <= rec_rd;
      old_rd       <= old_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (at_last_col) begin
        col <= '0;
        row <= (row == last_row) ? '0 : row + RW'(1);
      end else begin
        col <= col + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ctl.emit   <= (row != '0);
      s1_ctl.pass   <= (row == RW'(1)) || (col == '0) || at_last_col;
      s1_ctl.second <= (row == last_row);
      s1_ctl.done   <= at_last_col;
      s1_row        <= row - RW'(1);
      s1_col        <= col;
      s1_x          <= cell_data;
      s1_ctr        <= rec_rd;
      s1_dn         <= old_rd;
      s1_lft        <= prev_ctr;
      prev_ctr      <= rec_rd;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/ads_mac.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ads_mac
// Five weighted products, adder tree, rounding and saturation.
// ----------------------------------------------------------------------------
module ads_mac #(
  parameter int CW = 10,
  parameter int RW = 12
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               in_valid,
  input  ads_pkg::item_ctl_t                in_ctl,
  input  wire  [RW-1:0]                     in_row,
  input  wire  [CW-1:0]                     in_col,
  input  wire  [ads_pkg::VAL_W-1:0]         in_x,
  input  wire  [ads_pkg::VAL_W-1:0]         in_ctr,
  input  wire  [ads_pkg::VAL_W-1:0]         in_dn,
  input  wire  [ads_pkg::VAL_W-1:0]         in_lft,
  input  wire  [ads_pkg::VAL_W-1:0]         in_rgt,
  input  wire  signed [ads_pkg::WGT_W-1:0]  wc,
  input  wire  signed [ads_pkg::WGT_W-1:0]  wl,
  input  wire  signed [ads_pkg::WGT_W-1:0]  wr,
  input  wire  signed [ads_pkg::WGT_W-1:0]  wd,
  input  wire  signed [ads_pkg::WGT_W-1:0]  wu,
  output logic [2:0]                        stage_valid,
  output logic                              push1,
  output logic                              push2,
  output logic [ads_pkg::VAL_W-1:0]         val1,
  output logic [ads_pkg::VAL_W-1:0]         val2,
  output logic [RW-1:0]                     row1,
  output logic [RW-1:0]                     row2,
  output logic [CW-1:0]                     col,
  output logic                              done2
);
  import ads_pkg::*;

  logic v2, v3, v4;
  item_ctl_t ctl2, ctl3, ctl4;
  logic [RW-1:0] row2q, row3q, row4q;
  logic [CW-1:0] col2, col3, col4;
  logic [VAL_W-1:0] x2, x3, x4;
  logic [VAL_W-1:0] ctr2, ctr3, ctr4;

  logic signed [PROD_W-1:0] p0, p1, p2, p3, p4;
  logic signed [ACC_W-1:0]  s01, s23, s4;
  logic signed [ACC_W-1:0]  acc;
  logic signed [QUO_W-1:0]  quo;
  logic [QUO_W-VAL_W:0]     hi;
  logic [VAL_W-1:0]         sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v2 <= in_valid;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    p0    <= wc * $signed(in_ctr);
    p1    <= wl * $signed(in_lft);
    p2    <= wr * $signed(in_rgt);
    p3    <= wd * $signed(in_dn);
    p4    <= wu * $signed(in_x);
    ctl2  <= in_ctl;
    row2q <= in_row;
    col2  <= in_col;
    x2    <= in_x;
    ctr2  <= in_ctr;

    s01   <= ACC_W'(p0) + ACC_W'(p1);
    s23   <= ACC_W'(p2) + ACC_W'(p3);
    s4    <= ACC_W'(p4) + RND_BIAS;
    ctl3  <= ctl2;
    row3q <= row2q;
    col3  <= col2;
    x3    <= x2;
    ctr3  <= ctr2;

    acc   <= s01 + s23 + s4;
    ctl4  <= ctl3;
    row4q <= row3q;
    col4  <= col3;
    x4    <= x3;
    ctr4  <= ctr3;
  end

  // floor shift then clamp to the 32-bit range
  assign quo = QUO_W'(acc >>> FRAC_W);
  assign hi  = quo[QUO_W-1:VAL_W-1];

  always_comb begin
    if ((&hi) || (~|hi)) begin
      sat = quo[VAL_W-1:0];
    end else if (quo[QUO_W-1]) begin
      sat = VAL_MIN;
    end else begin
      sat = VAL_MAX;
    end
  end

  assign stage_valid = {v2, v3, v4};
  assign push1 = v4 && ctl4.emit;
  assign push2 = v4 && ctl4.emit && ctl4.second;
  assign val1  = ctl4.pass ? ctr4 : sat;
  assign val2  = x4;
  assign row1  = row4q;
  assign row2  = row4q + RW'(1);
  assign col   = col4;
  assign done2 = ctl4.done;

endmodule
`default_nettype wire

// ===== hw/rtl/ads_out_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ads_out_fifo
// Result queue taking up to two entries per cycle, one out per transfer.
// ----------------------------------------------------------------------------
module ads_out_fifo #(
  parameter int CW = 10,
  parameter int RW = 12
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          push1,
  input  wire                          push2,
  input  wire  [ads_pkg::VAL_W-1:0]    val1,
  input  wire  [ads_pkg::VAL_W-1:0]    val2,
  input  wire  [RW-1:0]                row1,
  input  wire  [RW-1:0]                row2,
  input  wire  [CW-1:0]                col,
  input  wire                          done2,
  input  wire                          pop,
  output logic                         not_empty,
  output logic [ads_pkg::VAL_W-1:0]    head_val,
  output logic [RW-1:0]                head_row,
  output logic [CW-1:0]                head_col,
  output logic                         head_done,
  output logic [ads_pkg::FIFO_AW:0]    count
);
  import ads_pkg::*;

  logic [VAL_W-1:0] q_val  [FIFO_DEPTH];
  logic [RW-1:0]    q_row  [FIFO_DEPTH];
  logic [CW-1:0]    q_col  [FIFO_DEPTH];
  logic             q_done [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wp, rp, wp1;

  assign wp1 = wp + FIFO_AW'(1);

  always_ff @(posedge clk) begin
    if (push1) begin
      q_val[wp]  <= val1;
      q_row[wp]  <= row1;
      q_col[wp]  <= col;
      q_done[wp] <= 1'b0;
    end
    if (push2) begin
      q_val[wp1]  <= val2;
      q_row[wp1]  <= row2;
      q_col[wp1]  <= col;
      q_done[wp1] <= done2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      wp    <= wp + FIFO_AW'(push1) + FIFO_AW'(push2);
      rp    <= rp + FIFO_AW'(pop);
      count <= count + (FIFO_AW+1)'(push1) + (FIFO_AW+1)'(push2) - (FIFO_AW+1)'(pop);
    end
  end

  assign not_empty = (count != '0);
  assign head_val  = q_val[rp];
  assign head_row  = q_row[rp];
  assign head_col  = q_col[rp];
  assign head_done = q_done[rp];

endmodule
`default_nettype wire

// ===== hw/rtl/advection_diffusion_stencil.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// advection_diffusion_stencil
// One explicit 5-point advection-diffusion step over a raster cell stream.
// ----------------------------------------------------------------------------
// Cells enter in raster order, halo columns included, one per clock while
// s_axis_tready is high. Each result belongs to the row above the incoming
// cell; halo columns and the first and last rows pass unchanged, and each
// cell of the last row also comes out itself right after the result above
// it, so the last row yields two results per cell and the output side sets
// the pace there. Each cell costs one read and one write on each of the two
// line memories, which caps the rate at one cell per clock. A cell's results
// pass the operand, product, sum and accumulator registers into the 16-entry
// output queue; s_axis_tready drops only when the queue could not hold two
// results per cell in flight or arriving. The line memories need no clearing
// after reset. Writing grid_width or grid_height restarts at row 0, column 0.
module advection_diffusion_stencil #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096,
  localparam int CW    = $clog2(MAX_WIDTH),
  localparam int RW    = $clog2(MAX_HEIGHT),
  localparam int OUT_W = ((ads_pkg::VAL_W + RW + CW + 7) / 8) * 8
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire  [ads_pkg::VAL_W-1:0]          s_axis_tdata,  // cell_value
  output logic                               m_axis_tvalid,
  input  wire                                m_axis_tready,
  output logic [OUT_W-1:0]                   m_axis_tdata,  // new_value, out_row, out_column
  output logic                               m_axis_tlast,  // grid_done
  input  wire                                cfg_we,
  input  wire  [ads_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire  [ads_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import ads_pkg::*;

  logic signed [WGT_W-1:0] wc, wl, wr, wd, wu;
  logic [GW_W-1:0] grid_width;
  logic [GH_W-1:0] grid_height;
  int wid_eff;
  int hgt_eff;
  logic [CW-1:0] last_col;
  logic [RW-1:0] last_row;
  logic restart;
  logic accept;

  logic            s1_valid;
  item_ctl_t       s1_ctl;
  logic [RW-1:0]   s1_row;
  logic [CW-1:0]   s1_col;
  logic [VAL_W-1:0] s1_x, s1_ctr, s1_dn, s1_lft, rgt;

  logic [2:0]       mac_valid;
  logic             push1, push2, done2;
  logic [VAL_W-1:0] val1, val2;
  logic [RW-1:0]    row1, row2;
  logic [CW-1:0]    res_col;

  logic             pop;
  logic [VAL_W-1:0] head_val;
  logic [RW-1:0]    head_row;
  logic [CW-1:0]    head_col;
  logic [FIFO_AW:0] count;
  logic [2:0]       inflight;
  logic [FIFO_AW+1:0] need;

  always_ff @(posedge clk) begin
    if (rst) begin
      wc          <= RST_WC;
      wl          <= RST_WL;
      wr          <= RST_WR;
      wd          <= RST_WD;
      wu          <= RST_WU;
      grid_width  <= RST_GW;
      grid_height <= RST_GH;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WC:     wc          <= cfg_data;
        REG_WL:     wl          <= cfg_data;
        REG_WR:     wr          <= cfg_data;
        REG_WD:     wd          <= cfg_data;
        REG_WU:     wu          <= cfg_data;
        REG_WIDTH:  grid_width  <= cfg_data[GW_W-1:0];
        REG_HEIGHT: grid_height <= cfg_data[GH_W-1:0];
        default:    ;
      endcase
    end
  end

  assign restart = cfg_we && ((cfg_index == REG_WIDTH) || (cfg_index == REG_HEIGHT));

  always_comb begin
    wid_eff = int'(grid_width);
    hgt_eff = int'(grid_height);
    if (wid_eff < 3) wid_eff = 3;
    if (wid_eff > MAX_WIDTH) wid_eff = MAX_WIDTH;
    if (hgt_eff < 3) hgt_eff = 3;
    if (hgt_eff > MAX_HEIGHT) hgt_eff = MAX_HEIGHT;
    last_col = CW'(wid_eff - 1);
    last_row = RW'(hgt_eff - 1);
  end

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign inflight = 3'($countones({s1_valid, mac_valid}));
  assign need     = (FIFO_AW+2)'(count) + (FIFO_AW+2)'({inflight, 1'b0});
  assign s_axis_tready = (need <= (FIFO_AW+2)'(FIFO_DEPTH - 2));

  ads_line_buf #(
    .MAX_WIDTH (MAX_WIDTH),
    .CW        (CW),
    .RW        (RW)
  ) u_line_buf (
    .clk       (clk),
    .rst       (rst),
    .restart   (restart),
    .accept    (accept),
    .cell_data (s_axis_tdata),
    .last_col  (last_col),
    .last_row  (last_row),
    .s1_valid  (s1_valid),
    .s1_ctl    (s1_ctl),
    .s1_row    (s1_row),
    .s1_col    (s1_col),
    .s1_x      (s1_x),
    .s1_ctr    (s1_ctr),
    .s1_dn     (s1_dn),
    .s1_lft    (s1_lft),
    .rgt       (rgt)
  );

  ads_mac #(
    .CW (CW),
    .RW (RW)
  ) u_mac (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s1_valid),
    .in_ctl      (s1_ctl),
    .in_row      (s1_row),
    .in_col      (s1_col),
    .in_x        (s1_x),
    .in_ctr      (s1_ctr),
    .in_dn       (s1_dn),
    .in_lft      (s1_lft),
    .in_rgt      (rgt),
    .wc          (wc),
    .wl          (wl),
    .wr          (wr),
    .wd          (wd),
    .wu          (wu),
    .stage_valid (mac_valid),
    .push1       (push1),
    .push2       (push2),
    .val1        (val1),
    .val2        (val2),
    .row1        (row1),
    .row2        (row2),
    .col         (res_col),
    .done2       (done2)
  );

  assign pop = m_axis_tvalid && m_axis_tready;

  ads_out_fifo #(
    .CW (CW),
    .RW (RW)
  ) u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push1     (push1),
    .push2     (push2),
    .val1      (val1),
    .val2      (val2),
    .row1      (row1),
    .row2      (row2),
    .col       (res_col),
    .done2     (done2),
    .pop       (pop),
    .not_empty (m_axis_tvalid),
    .head_val  (head_val),
    .head_row  (head_row),
    .head_col  (head_col),
    .head_done (m_axis_tlast),
    .count     (count)
  );

  assign m_axis_tdata = OUT_W'({head_col, head_row, head_val});

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= (FIFO_AW+1)'(FIFO_DEPTH))
    else $error("result queue overflow");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_valid)
    else $error("accepted cell missing from the operand stage");

  a_last_at_corner: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tlast) |-> (head_row == last_row && head_col == last_col))
    else $error("grid end flagged away from the last cell");

  a_stall_has_cause: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (count != '0 || inflight != '0))
    else $error("input stalled with nothing in flight");
`endif

endmodule
`default_nettype wire
